// ===== rtl/cmsu_pkg.sv =====
// Shared types and constants for the cluster mean/spread update block.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps
package cmsu_pkg;

   localparam int DIV_STEPS = 34;
   localparam logic [33:0] ONE_Q32 = 34'h1_0000_0000;
   localparam logic [6:0] DIMS_RESET = 7'd64;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_EMPTY = 2'd1,
      FAULT_SAT   = 2'd2
   } fault_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIV,
      FR_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_DIFF,
      BK_MA,
      BK_MB,
      BK_MC,
      BK_MD,
      BK_INNER,
      BK_ME,
      BK_MF,
      BK_DONE
   } back_state_type;

   // one classified coordinate, with the factors of its point
   typedef struct packed {
      logic signed [31:0] x;
      logic               last;
      logic               zero;
      logic               neg;
      logic [32:0]        rec;
      logic [33:0]        keep;
      logic [31:0]        count;
      fault_type          fault;
   } item_type;

endpackage

// ===== rtl/cmsu_front.sv =====
// Front end: input transfer, coordinate counter, point count and factor divider.
// Depends on cmsu_pkg.
`timescale 1ns / 1ps
module cmsu_front #(
   parameter int MAX_DIMS = 64,
   parameter int IDXW     = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic signed [31:0]    req_coord_value,
   input  logic                  csr_wr_en,
   input  logic [6:0]            csr_wr_data,
   output logic                  q_push,
   input  logic                  q_space,
   output cmsu_pkg::item_type    q_item,
   output logic [IDXW-1:0]       q_idx
);

   cmsu_pkg::front_state_type state_ff, state_in;
   logic [6:0]         dims_ff;
   logic [IDXW-1:0]    coord_cnt_ff;
   logic [31:0]        count_ff;
   logic [5:0]         step_ff;
   logic               op_ff;
   logic               last_ff;
   logic               zero_ff;
   logic               neg_ff;
   logic [32:0]        rec_ff;
   logic [33:0]        keep_ff;
   cmsu_pkg::fault_type fault_ff;
   logic signed [31:0] x_ff;
   logic [IDXW-1:0]    idx_ff;
   logic [32:0]        div_n_ff;
   logic [33:0]        dvd_ff;
   logic [32:0]        rem_ff;
   logic [33:0]        quo_ff;

   logic [31:0] eff;
   logic        last_in;
   logic        accept;
   logic [33:0] rem_sh;
   logic        ge;
   logic [33:0] rem_nx;
   logic [33:0] quo_nx;
   logic [32:0] n_in;
   logic [31:0] cnt_after;

   always_comb begin
      eff = 32'(dims_ff);
      if (eff == 32'd0) begin
         eff = 32'd1;
      end
      if (eff > 32'(MAX_DIMS)) begin
         eff = 32'(MAX_DIMS);
      end
   end

   assign last_in = (32'(coord_cnt_ff) + 32'd1) >= eff;
   assign accept  = req_valid && req_ready;
   assign n_in    = (req_op == cmsu_pkg::OP_REMOVE) ? ({1'b0, count_ff} - 33'd1)
                                                    : ({1'b0, count_ff} + 33'd1);

   // restoring divider step, one quotient bit a cycle
   assign rem_sh = {rem_ff, dvd_ff[33]};
   assign ge     = rem_sh >= {1'b0, div_n_ff};
   assign rem_nx = ge ? (rem_sh - {1'b0, div_n_ff}) : rem_sh;
   assign quo_nx = {quo_ff[32:0], ge};

   assign cnt_after = (fault_ff != cmsu_pkg::FAULT_NONE) ? count_ff :
                      (op_ff == cmsu_pkg::OP_REMOVE) ? (count_ff - 32'd1) : (count_ff + 32'd1);

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      q_push    = 1'b0;
      case (state_ff)
         cmsu_pkg::FR_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (coord_cnt_ff == '0 &&
                   !(req_op == cmsu_pkg::OP_REMOVE && count_ff <= 32'd1)) begin
                  state_in = cmsu_pkg::FR_DIV;
               end else begin
                  state_in = cmsu_pkg::FR_PUSH;
               end
            end
         end
         cmsu_pkg::FR_DIV: begin
            if (step_ff == 6'(cmsu_pkg::DIV_STEPS - 1)) begin
               state_in = cmsu_pkg::FR_PUSH;
            end
         end
         cmsu_pkg::FR_PUSH: begin
            if (q_space) begin
               q_push   = 1'b1;
               state_in = cmsu_pkg::FR_IDLE;
            end
         end
         default: state_in = cmsu_pkg::FR_IDLE;
      endcase
   end

   always_comb begin
      q_item.x     = x_ff;
      q_item.last  = last_ff;
      q_item.zero  = zero_ff;
      q_item.neg   = neg_ff;
      q_item.rec   = rec_ff;
      q_item.keep  = keep_ff;
      q_item.count = cnt_after;
      q_item.fault = fault_ff;
      q_idx        = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cmsu_pkg::FR_IDLE;
         dims_ff      <= cmsu_pkg::DIMS_RESET;
         coord_cnt_ff <= '0;
         count_ff     <= '0;
         step_ff      <= '0;
         op_ff        <= 1'b0;
         zero_ff      <= 1'b0;
         neg_ff       <= 1'b0;
         rec_ff       <= '0;
         keep_ff      <= '0;
         fault_ff     <= cmsu_pkg::FAULT_NONE;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            dims_ff <= csr_wr_data;
         end
         if (accept) begin
            x_ff         <= req_coord_value;
            idx_ff       <= coord_cnt_ff;
            last_ff      <= last_in;
            coord_cnt_ff <= last_in ? '0 : IDXW'(coord_cnt_ff + 1'b1);
            if (coord_cnt_ff == '0) begin
               op_ff  <= req_op;
               neg_ff <= 1'b0;
               zero_ff <= 1'b0;
               if (req_op == cmsu_pkg::OP_REMOVE && count_ff == 32'd0) begin
                  fault_ff <= cmsu_pkg::FAULT_EMPTY;
                  keep_ff  <= cmsu_pkg::ONE_Q32;
                  rec_ff   <= '0;
               end else if (req_op == cmsu_pkg::OP_REMOVE && count_ff == 32'd1) begin
                  // last point leaves: both stores get cleared
                  fault_ff <= cmsu_pkg::FAULT_NONE;
                  zero_ff  <= 1'b1;
                  keep_ff  <= '0;
                  rec_ff   <= '0;
               end else begin
                  fault_ff <= (req_op != cmsu_pkg::OP_REMOVE && count_ff == 32'hFFFF_FFFF)
                              ? cmsu_pkg::FAULT_SAT : cmsu_pkg::FAULT_NONE;
                  neg_ff   <= req_op;
                  div_n_ff <= n_in;
                  dvd_ff   <= cmsu_pkg::ONE_Q32 + {2'b0, n_in[32:1]};
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  step_ff  <= '0;
               end
            end
         end
         if (state_ff == cmsu_pkg::FR_DIV) begin
            rem_ff  <= rem_nx[32:0];
            quo_ff  <= quo_nx;
            dvd_ff  <= {dvd_ff[32:0], 1'b0};
            step_ff <= step_ff + 6'd1;
            if (step_ff == 6'(cmsu_pkg::DIV_STEPS - 1)) begin
               rec_ff  <= quo_nx[32:0];
               keep_ff <= (op_ff == cmsu_pkg::OP_REMOVE)
                          ? (cmsu_pkg::ONE_Q32 + {1'b0, quo_nx[32:0]})
                          : (cmsu_pkg::ONE_Q32 - {1'b0, quo_nx[32:0]});
            end
         end
         if (q_push && last_ff) begin
            count_ff <= cnt_after;
         end
      end
   end

   a_last_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && last_in) |=> (coord_cnt_ff == '0))
      else $error("coordinate counter did not wrap after last coordinate");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cmsu_pkg::FR_DIV) |-> (step_ff < 6'(cmsu_pkg::DIV_STEPS)))
      else $error("divider ran past its step count");

   a_zero_factors: assert property (@(posedge clock) disable iff (reset)
      (q_push && zero_ff) |-> (keep_ff == '0 && rec_ff == '0))
      else $error("clearing point carries nonzero factors");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (q_push && !last_ff) |=> $stable(count_ff))
      else $error("point count moved before the last coordinate");

endmodule

// ===== rtl/cmsu_queue.sv =====
// Two-entry queue between front and back ends.
// Depends on cmsu_pkg.
`timescale 1ns / 1ps
module cmsu_queue #(
   parameter int IDXW = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cmsu_pkg::item_type   item_in,
   input  logic [IDXW-1:0]      idx_in,
   output logic                 space,
   output logic                 valid,
   input  logic                 pop,
   output cmsu_pkg::item_type   item_out,
   output logic [IDXW-1:0]      idx_out
);

   cmsu_pkg::item_type ent_ff [2];
   logic [IDXW-1:0]    idx_ff [2];
   logic               wr_ptr_ff;
   logic               rd_ptr_ff;
   logic [1:0]         fill_ff;

   assign space    = fill_ff != 2'd2;
   assign valid    = fill_ff != 2'd0;
   assign item_out = ent_ff[rd_ptr_ff];
   assign idx_out  = idx_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= item_in;
         idx_ff[wr_ptr_ff] <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ===== rtl/cmsu_back.sv =====
// Back end: statistics stores, shared multiplier sequence and result register.
// Depends on cmsu_pkg.
`timescale 1ns / 1ps
module cmsu_back #(
   parameter int MAX_DIMS  = 64,
   parameter int FRAC_BITS = 16,
   parameter int IDXW      = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_pop,
   input  cmsu_pkg::item_type  q_item,
   input  logic [IDXW-1:0]     q_idx,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [5:0]          rsp_dim_index,
   output logic signed [31:0]  rsp_mean_value,
   output logic [47:0]         rsp_spread_value,
   output logic [31:0]         rsp_point_count,
   output logic                rsp_last_coord,
   output logic [1:0]          rsp_fault
);

   localparam int SH   = 32 + FRAC_BITS;
   localparam int AW   = 65 - FRAC_BITS;
   localparam int IN_W = ((AW > 48) ? AW : 48) + 1;

   cmsu_pkg::back_state_type state_ff, state_in;

   logic signed [31:0] mean_mem [MAX_DIMS];
   logic [47:0]        spread_mem [MAX_DIMS];
   logic [MAX_DIMS-1:0] vld_ff;

   cmsu_pkg::item_type item_ff;
   logic [IDXW-1:0]    idx_ff;
   logic signed [31:0] rd_mean_ff;
   logic [47:0]        rd_spread_ff;
   logic               rd_vld_ff;
   logic               diff_neg_ff;
   logic [31:0]        ad_ff;
   logic [67:0]        prod_ff;
   logic [67:0]        acc_ff;
   logic [31:0]        sq_hi_ff;
   logic signed [31:0] mnew_ff;
   logic [IN_W-1:0]    inner_ff;
   logic               rsp_valid_ff;

   logic signed [31:0] mcur;
   logic [47:0]        vcur;
   logic signed [32:0] diff;
   logic [33:0]        mul_a;
   logic [33:0]        mul_b;
   logic [67:0]        prod_in;
   logic [67:0]        rnd_m;
   logic [32:0]        term;
   logic signed [34:0] msum;
   logic signed [31:0] msat;
   logic [99:0]        fa;
   logic [AW-1:0]      a_val;
   logic [IN_W-1:0]    vx;
   logic [IN_W-1:0]    ax;
   logic [IN_W-1:0]    inner;
   logic [99:0]        fv;
   logic [67:0]        vq;
   logic [47:0]        vnew;
   logic signed [31:0] mnew;
   logic               finish;
   logic [31:0]        idx32;

   assign mcur = rd_vld_ff ? rd_mean_ff : 32'sd0;
   assign vcur = rd_vld_ff ? rd_spread_ff : 48'd0;
   assign diff = 33'(item_ff.x) - 33'(mcur);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         cmsu_pkg::BK_MA: begin
            mul_a = {1'b0, item_ff.rec};
            mul_b = {2'b0, ad_ff};
         end
         cmsu_pkg::BK_MB: begin
            mul_a = {2'b0, ad_ff};
            mul_b = {2'b0, ad_ff};
         end
         cmsu_pkg::BK_MC: begin
            mul_a = {1'b0, item_ff.rec};
            mul_b = {2'b0, prod_ff[31:0]};
         end
         cmsu_pkg::BK_MD: begin
            mul_a = {1'b0, item_ff.rec};
            mul_b = {2'b0, sq_hi_ff};
         end
         cmsu_pkg::BK_ME: begin
            mul_a = item_ff.keep;
            mul_b = {2'b0, inner_ff[31:0]};
         end
         cmsu_pkg::BK_MF: begin
            mul_a = item_ff.keep;
            mul_b = 34'(inner_ff[IN_W-1:32]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // mean step, rounded half away from zero on the magnitude
   assign rnd_m = prod_ff + 68'h8000_0000;
   assign term  = rnd_m[64:32];
   assign msum  = (item_ff.neg ^ diff_neg_ff) ? (35'(mcur) - $signed({2'b0, term}))
                                              : (35'(mcur) + $signed({2'b0, term}));
   always_comb begin
      if (msum > 35'sh0_7FFF_FFFF) begin
         msat = 32'sh7FFF_FFFF;
      end else if (msum < -35'sh0_8000_0000) begin
         msat = -32'sh8000_0000;
      end else begin
         msat = msum[31:0];
      end
   end

   // variance correction term and inner sum
   assign fa    = {prod_ff, 32'b0} + {32'b0, acc_ff} + (100'd1 << (SH - 1));
   assign a_val = fa[SH+AW-1:SH];
   assign vx    = IN_W'(vcur);
   assign ax    = IN_W'(a_val);
   assign inner = item_ff.neg ? ((vx > ax) ? (vx - ax) : '0) : (vx + ax);

   assign fv = {prod_ff, 32'b0} + {32'b0, acc_ff} + 100'h8000_0000;
   assign vq = fv[99:32];
   assign vnew = item_ff.zero ? 48'd0 :
                 (vq > 68'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : vq[47:0];
   assign mnew = item_ff.zero ? 32'sd0 : mnew_ff;

   assign finish = (state_ff == cmsu_pkg::BK_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      case (state_ff)
         cmsu_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = q_item.zero ? cmsu_pkg::BK_DONE : cmsu_pkg::BK_DIFF;
            end
         end
         cmsu_pkg::BK_DIFF:  state_in = cmsu_pkg::BK_MA;
         cmsu_pkg::BK_MA:    state_in = cmsu_pkg::BK_MB;
         cmsu_pkg::BK_MB:    state_in = cmsu_pkg::BK_MC;
         cmsu_pkg::BK_MC:    state_in = cmsu_pkg::BK_MD;
         cmsu_pkg::BK_MD:    state_in = cmsu_pkg::BK_INNER;
         cmsu_pkg::BK_INNER: state_in = cmsu_pkg::BK_ME;
         cmsu_pkg::BK_ME:    state_in = cmsu_pkg::BK_MF;
         cmsu_pkg::BK_MF:    state_in = cmsu_pkg::BK_DONE;
         cmsu_pkg::BK_DONE: begin
            if (finish) begin
               state_in = cmsu_pkg::BK_IDLE;
            end
         end
         default: state_in = cmsu_pkg::BK_IDLE;
      endcase
   end

   // stores: registered read at pop, write when the result is loaded
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_mean_ff   <= mean_mem[q_idx];
         rd_spread_ff <= spread_mem[q_idx];
      end
      if (finish) begin
         mean_mem[idx_ff]   <= mnew;
         spread_mem[idx_ff] <= vnew;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cmsu_pkg::BK_IDLE;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            vld_ff[idx_ff] <= 1'b1;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign idx32 = 32'(idx_ff);

   always_ff @(posedge clock) begin
      // last product is held while the result waits for the output register
      if (state_ff != cmsu_pkg::BK_DONE) begin
         prod_ff <= prod_in;
      end
      if (q_pop) begin
         item_ff   <= q_item;
         idx_ff    <= q_idx;
         rd_vld_ff <= vld_ff[q_idx];
      end
      case (state_ff)
         cmsu_pkg::BK_DIFF: begin
            diff_neg_ff <= diff[32];
            ad_ff       <= diff[32] ? 32'(-diff) : diff[31:0];
         end
         cmsu_pkg::BK_MB:    mnew_ff  <= msat;
         cmsu_pkg::BK_MC:    sq_hi_ff <= prod_ff[63:32];
         cmsu_pkg::BK_MD:    acc_ff   <= prod_ff;
         cmsu_pkg::BK_INNER: inner_ff <= inner;
         cmsu_pkg::BK_MF:    acc_ff   <= prod_ff;
         default: begin
         end
      endcase
      if (finish) begin
         rsp_dim_index    <= idx32[5:0];
         rsp_mean_value   <= mnew;
         rsp_spread_value <= vnew;
         rsp_point_count  <= item_ff.count;
         rsp_last_coord   <= item_ff.last;
         rsp_fault        <= item_ff.fault;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/cluster_mean_spread_update.sv =====
// Top level of the cluster mean/spread update block.
// Depends on cmsu_pkg, cmsu_front, cmsu_queue and cmsu_back.
`timescale 1ns / 1ps
//
//  channel   ports                         direction  transfer
//  req       req_valid/req_ready, payload  in         valid & ready at clock edge
//  rsp       rsp_valid/rsp_ready, payload  out        valid & ready at clock edge
//  csr       csr_wr_en, csr_wr_data        in         every edge with csr_wr_en high
//
//  The back end uses one shared 34x34 multiplier six times in sequence per coordinate;
//    a clearing point skips the multiplier sequence.
//  The first coordinate of a point runs the bit-serial reciprocal of the new count in
//    the front end (skipped for empty removal or clear).
//  Synchronous active-high reset; the stores read as zero until written.
//  A two-entry queue decouples front and back; a held result stalls the input only
//    once the result register, the queue and the front register are all full.
module cluster_mean_spread_update #(
   parameter int MAX_DIMS  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic signed [31:0] req_coord_value,
   input  logic               csr_wr_en,
   input  logic [6:0]         csr_wr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_dim_index,
   output logic signed [31:0] rsp_mean_value,
   output logic [47:0]        rsp_spread_value,
   output logic [31:0]        rsp_point_count,
   output logic               rsp_last_coord,
   output logic [1:0]         rsp_fault
);

   localparam int IDXW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   // front to queue
   logic               push;
   logic               space;
   cmsu_pkg::item_type push_item;
   logic [IDXW-1:0]    push_idx;

   // queue to back
   logic               head_valid;
   logic               pop;
   cmsu_pkg::item_type head_item;
   logic [IDXW-1:0]    head_idx;

   cmsu_front #(
      .MAX_DIMS (MAX_DIMS),
      .IDXW     (IDXW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_coord_value (req_coord_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .q_push          (push),
      .q_space         (space),
      .q_item          (push_item),
      .q_idx           (push_idx)
   );

   cmsu_queue #(
      .IDXW (IDXW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .item_in  (push_item),
      .idx_in   (push_idx),
      .space    (space),
      .valid    (head_valid),
      .pop      (pop),
      .item_out (head_item),
      .idx_out  (head_idx)
   );

   // the back end owns the stores and the result register
   cmsu_back #(
      .MAX_DIMS  (MAX_DIMS),
      .FRAC_BITS (FRAC_BITS),
      .IDXW      (IDXW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (head_valid),
      .q_pop            (pop),
      .q_item           (head_item),
      .q_idx            (head_idx),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dim_index    (rsp_dim_index),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_spread_value (rsp_spread_value),
      .rsp_point_count  (rsp_point_count),
      .rsp_last_coord   (rsp_last_coord),
      .rsp_fault        (rsp_fault)
   );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for cluster_mean_spread_update: directed table plus random points.
// Depends on cmsu_pkg and the RTL top level; the expected statistics come from a local predictor.
`timescale 1ns / 1ps
module tb;

   localparam logic OP_ADD  = 1'b0;
   localparam int   DEPTH   = 64;
   localparam int   FRACB   = 16;
   localparam int   SETTLE  = 100;    // back end drain time after the last result
   localparam int   WD_MAX  = 5000;   // cycles without any transfer before giving up
   localparam int   HOLD_CY = 300;    // long receiver hold-off

   typedef struct {
      logic [5:0]          dim;
      logic [31:0]         mean;
      logic [47:0]         spread;
      logic [31:0]         count;
      logic                last;
      cmsu_pkg::fault_type fault;
   } stats_type;

   typedef struct {
      logic        op;
      logic [31:0] x;
      logic        typed;
      stats_type   want;
   } row_type;

   logic clock, reset;
   logic req_valid, req_ready, req_op;
   logic signed [31:0] req_coord_value;
   logic csr_wr_en;
   logic [6:0] csr_wr_data;
   logic rsp_valid, rsp_ready;
   logic [5:0] rsp_dim_index;
   logic signed [31:0] rsp_mean_value;
   logic [47:0] rsp_spread_value;
   logic [31:0] rsp_point_count;
   logic rsp_last_coord;
   logic [1:0] rsp_fault;

   cluster_mean_spread_update DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_op(req_op), .req_coord_value(req_coord_value),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_dim_index(rsp_dim_index), .rsp_mean_value(rsp_mean_value),
      .rsp_spread_value(rsp_spread_value), .rsp_point_count(rsp_point_count),
      .rsp_last_coord(rsp_last_coord), .rsp_fault(rsp_fault)
   );

   // predictor state: mirrors the cluster statistics held in the block
   logic [31:0] mean_mem [DEPTH];
   logic [63:0] spread_mem [DEPTH];
   logic [31:0] pt_count;
   int          coord_pos;
   logic        pt_op;
   logic [63:0] keep_q32;
   longint      step_q32;
   cmsu_pkg::fault_type pt_fault;
   int          dims_cfg;

   stats_type   stats_due [$];
   int          n_sent, n_got, n_bad, n_points, n_empty, n_cleared;
   int          quiet_cycles;
   bit          hold_req;
   bit          hold_done;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // round-half-up of (a*b) >> sh, saturated to 64 bits
   function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      if (p[127:64] != 0) return '1;
      return p[63:0];
   endfunction

   function automatic stats_type update_stats(logic op, logic [31:0] xin);
      stats_type s;
      int eff, i;
      logic [63:0] n, recip, ad, rec, term, a, inner, vnew;
      longint m, x, diff, mnew;
      logic [31:0] cnt_next;
      eff = (dims_cfg < 1) ? 1 : (dims_cfg > DEPTH) ? DEPTH : dims_cfg;
      if (coord_pos == 0) begin
         pt_op = op;
         if (op == cmsu_pkg::OP_REMOVE && pt_count == 0) begin
            pt_fault = cmsu_pkg::FAULT_EMPTY;
            keep_q32 = 64'd1 << 32;
            step_q32 = 0;
         end else if (op == cmsu_pkg::OP_REMOVE && pt_count == 1) begin
            pt_fault = cmsu_pkg::FAULT_NONE;   // last point leaves: clear mode
            keep_q32 = 0;
            step_q32 = 0;
         end else begin
            n = (op == cmsu_pkg::OP_REMOVE) ? {32'd0, pt_count} - 1 : {32'd0, pt_count} + 1;
            recip = ((64'd1 << 32) + n / 2) / n;
            pt_fault = (op == OP_ADD && pt_count == 32'hFFFF_FFFF) ? cmsu_pkg::FAULT_SAT
                                                                 : cmsu_pkg::FAULT_NONE;
            keep_q32 = (op == cmsu_pkg::OP_REMOVE) ? (64'd1 << 32) + recip
                                                   : (64'd1 << 32) - recip;
            step_q32 = (op == cmsu_pkg::OP_REMOVE) ? -longint'(recip) : longint'(recip);
         end
      end
      i = (coord_pos >= DEPTH) ? DEPTH - 1 : coord_pos;
      m = longint'($signed(mean_mem[i]));
      x = longint'($signed(xin));
      if (keep_q32 == 0 && step_q32 == 0) begin
         mnew = 0;
         vnew = 0;
      end else begin
         diff = x - m;
         ad   = (diff < 0) ? -diff : diff;
         rec  = (step_q32 < 0) ? -step_q32 : step_q32;
         term = mul_round(rec, ad, 32);
         mnew = ((step_q32 < 0) != (diff < 0)) ? m - longint'(term) : m + longint'(term);
         if (mnew > 64'sd2147483647) mnew = 64'sd2147483647;
         if (mnew < -64'sd2147483648) mnew = -64'sd2147483648;
         a = mul_round(rec, ad * ad, 32 + FRACB);
         if (step_q32 < 0) inner = (spread_mem[i] > a) ? spread_mem[i] - a : 0;
         else inner = spread_mem[i] + a;
         vnew = mul_round(keep_q32, inner, 32);
         if (vnew > 64'hFFFF_FFFF_FFFF) vnew = 64'hFFFF_FFFF_FFFF;
      end
      mean_mem[i]   = mnew[31:0];
      spread_mem[i] = vnew;
      if (pt_fault != cmsu_pkg::FAULT_NONE) cnt_next = pt_count;
      else cnt_next = (pt_op == cmsu_pkg::OP_REMOVE) ? pt_count - 1 : pt_count + 1;
      s.dim    = i[5:0];
      s.mean   = mnew[31:0];
      s.spread = vnew[47:0];
      s.count  = cnt_next;
      s.last   = (coord_pos + 1 >= eff);
      s.fault  = pt_fault;
      if (s.last) begin
         n_points++;
         if (pt_fault == cmsu_pkg::FAULT_EMPTY) n_empty++;
         if (keep_q32 == 0 && step_q32 == 0) n_cleared++;
         pt_count  = cnt_next;
         coord_pos = 0;
      end else begin
         coord_pos++;
      end
      return s;
   endfunction

   // one input transfer; valid stays high afterwards, the caller lowers it on a gap
   task automatic send_coord(logic op, logic [31:0] x, logic typed, stats_type want);
      stats_type s;
      req_valid       <= 1'b1;
      req_op          <= op;
      req_coord_value <= x;
      do @(posedge clock); while (!req_ready);
      s = update_stats(op, x);
      stats_due.insert(stats_due.size(), typed ? want : s);
      n_sent++;
   endtask

   task automatic gap(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // only with nothing in flight
   task automatic write_dims(int v);
      req_valid <= 1'b0;
      while (stats_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v[6:0];
      @(posedge clock);
      dims_cfg = v;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;  // near zero
         default: return $urandom;
      endcase
   endfunction

   // receiver: ready pattern redrawn from three modes, plus one long hold-off on request
   initial begin
      int mode, k;
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         for (k = 0; k < 64; k++) begin
            @(posedge clock);
            if (hold_req && !hold_done) begin
               rsp_ready <= 1'b0;
               repeat (HOLD_CY) @(posedge clock);
               hold_done = 1'b1;
            end
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= $urandom_range(0, 1);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // result checker: oldest expectation first
   always @(posedge clock) begin
      stats_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         n_got++;
         if (stats_due.size() == 0) begin
            n_bad++;
            if (n_bad <= 10) $display("unexpected result dim %0d", rsp_dim_index);
         end else begin
            e = stats_due.pop_front();
            if (rsp_dim_index !== e.dim || rsp_mean_value !== e.mean ||
                rsp_spread_value !== e.spread || rsp_point_count !== e.count ||
                rsp_last_coord !== e.last || rsp_fault !== e.fault) begin
               n_bad++;
               if (n_bad <= 10)
                  $display("result %0d: exp dim %0d mean %h spread %h count %0d last %b fault %0d",
                           n_got, e.dim, e.mean, e.spread, e.count, e.last, e.fault,
                           " / got dim %0d mean %h spread %h count %0d last %b fault %0d",
                           rsp_dim_index, rsp_mean_value, rsp_spread_value,
                           rsp_point_count, rsp_last_coord, rsp_fault);
            end
         end
      end
   end

   // watchdog on stalled progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_MAX) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      row_type rows [$];
      row_type r;
      stats_type none;
      int phase_dims [8] = '{3, 1, 64, 2, 127, 0, 7, 5};
      int phase_len  [8] = '{240, 150, 256, 150, 128, 100, 210, 150};
      int p, k, burst;

      reset = 1'b1;
      req_valid = 1'b0; req_op = 1'b0; req_coord_value = '0;
      csr_wr_en = 1'b0; csr_wr_data = '0;
      hold_req = 1'b0;
      quiet_cycles = 0;
      n_sent = 0; n_got = 0; n_bad = 0; n_points = 0; n_empty = 0; n_cleared = 0;
      for (k = 0; k < DEPTH; k++) begin
         mean_mem[k] = '0;
         spread_mem[k] = '0;
      end
      pt_count = 0; coord_pos = 0; pt_op = OP_ADD; keep_q32 = 0; step_q32 = 0;
      pt_fault = cmsu_pkg::FAULT_NONE; dims_cfg = int'(cmsu_pkg::DIMS_RESET);
      none = '{dim: 0, mean: 0, spread: 0, count: 0, last: 0, fault: cmsu_pkg::FAULT_NONE};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, one coordinate per point
      write_dims(1);
      // removal from an empty cluster: ignored, flagged
      rows.insert(rows.size(), '{cmsu_pkg::OP_REMOVE, 32'd5, 1'b1,
                       '{0, 32'd0, 48'd0, 32'd0, 1'b1, cmsu_pkg::FAULT_EMPTY}});
      // first point: mean takes the coordinate, spread stays zero
      rows.insert(rows.size(), '{OP_ADD, 32'h7FFF_FFFF, 1'b1,
                       '{0, 32'h7FFF_FFFF, 48'd0, 32'd1, 1'b1, cmsu_pkg::FAULT_NONE}});
      // last point removed: stores cleared
      rows.insert(rows.size(), '{cmsu_pkg::OP_REMOVE, 32'h1234_5678, 1'b1,
                       '{0, 32'd0, 48'd0, 32'd0, 1'b1, cmsu_pkg::FAULT_NONE}});
      rows.insert(rows.size(), '{OP_ADD, 32'h8000_0000, 1'b1,
                       '{0, 32'h8000_0000, 48'd0, 32'd1, 1'b1, cmsu_pkg::FAULT_NONE}});
      rows.insert(rows.size(), '{OP_ADD, 32'h7FFF_FFFF, 1'b0, none});  // widest difference
      rows.insert(rows.size(), '{OP_ADD, 32'h0000_0000, 1'b0, none});
      rows.insert(rows.size(), '{OP_ADD, 32'hFFFF_FFFF, 1'b0, none});
      rows.insert(rows.size(), '{cmsu_pkg::OP_REMOVE, 32'h7FFF_FFFF, 1'b0, none});
      // spread clamp on removal
      rows.insert(rows.size(), '{cmsu_pkg::OP_REMOVE, 32'h8000_0000, 1'b0, none});
      rows.insert(rows.size(), '{OP_ADD, 32'h0001_0000, 1'b0, none});
      rows.insert(rows.size(), '{cmsu_pkg::OP_REMOVE, 32'h0000_0001, 1'b0, none});
      rows.insert(rows.size(), '{cmsu_pkg::OP_REMOVE, 32'h5555_5555, 1'b0, none});
      // last point removed, then removal from the empty cluster
      rows.insert(rows.size(), '{cmsu_pkg::OP_REMOVE, 32'hAAAA_AAAA, 1'b0, none});
      rows.insert(rows.size(), '{cmsu_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, none});
      foreach (rows[k]) begin
         r = rows[k];
         send_coord(r.op, r.x, r.typed, r.want);
      end

      // random points, one dims setting per phase
      burst = $urandom_range(1, 30);
      for (p = 0; p < 8; p++) begin
         write_dims(phase_dims[p]);
         for (k = 0; k < phase_len[p]; k++) begin
            if (p == 2 && k == 40) hold_req = 1'b1;   // fill the block while output is held
            send_coord($urandom_range(0, 9) < 4, pick_coord(), 1'b0, none);
            burst--;
            if (burst == 0) begin
               if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 12));
               burst = $urandom_range(1, 30);
            end
         end
      end

      req_valid <= 1'b0;
      while (stats_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d coordinates in %0d points over 9 dims settings", n_sent, n_points);
      $display("%0d empty removals, %0d last-point clears, %0d results checked",
               n_empty, n_cleared, n_got);
      if (n_bad == 0 && stats_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
